[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SMM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: property failed");

// Condition must never be seen outside reset.
`define SMM_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");

`endif

[rtl/smm_pkg.sv]
// ----------------------------------------------------------------------------
// smm_pkg
// Shared constants, codes and types of the matrix multiply block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package smm_pkg;

   localparam int DEF_MAX_DIM  = 32;
   localparam int DEF_ACC_BITS = 32;

   localparam int ELEM_W      = 16;
   localparam int PROD_W      = 32;
   localparam int CMD_W       = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int SIZE_W      = 6;
   localparam int SHIFT_W     = 5;
   localparam int MODE_W      = 2;
   localparam int CSR_DATA_W  = 6;

   localparam int RESET_SIZE = 4;
   localparam logic [SHIFT_W-1:0] RESET_SHIFT = 5'd7;

   // input commands
   localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
   localparam logic [CMD_W-1:0] CMD_EMIT   = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MATRIX_SIZE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROUND_SHIFT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRANSPOSE   = 2'd2;

   // transpose modes
   localparam logic [MODE_W-1:0] MODE_PLAIN = 2'd0;
   localparam logic [MODE_W-1:0] MODE_B_T   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_A_T   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_ROUND,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic clear;
      logic acc_en;
      logic round_en;
   } mac_ctl_type;

   typedef struct packed {
      logic we_a;
      logic we_b;
   } store_wr_type;

endpackage

`default_nettype wire

[rtl/smm_store.sv]
// ----------------------------------------------------------------------------
// smm_store
// Element stores for both operands, one write and one registered read each.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smm_store
   import smm_pkg::*;
#(
   parameter int DEPTH  = DEF_MAX_DIM * DEF_MAX_DIM,
   parameter int ADDR_W = $clog2(DEF_MAX_DIM * DEF_MAX_DIM)
) (
   input  wire logic                     clock,
   input  wire store_wr_type             wr,
   input  wire logic [ADDR_W-1:0]        wr_addr,
   input  wire logic signed [ELEM_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0]        rd_addr_a,
   input  wire logic [ADDR_W-1:0]        rd_addr_b,
   output logic signed [ELEM_W-1:0]      rd_data_a,
   output logic signed [ELEM_W-1:0]      rd_data_b
);

   logic signed [ELEM_W-1:0] mem_a [DEPTH];
   logic signed [ELEM_W-1:0] mem_b [DEPTH];

   always_ff @(posedge clock) begin
      if (wr.we_a) begin
         mem_a[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_a[rd_addr_a];
   end

   always_ff @(posedge clock) begin
      if (wr.we_b) begin
         mem_b[wr_addr] <= wr_data;
      end
      rd_data_b <= mem_b[rd_addr_b];
   end

endmodule

`default_nettype wire

[rtl/smm_mac.sv]
// ----------------------------------------------------------------------------
// smm_mac
// Shared multiply-accumulate unit with rounding add and arithmetic shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smm_mac
   import smm_pkg::*;
#(
   parameter int ACC_BITS = DEF_ACC_BITS
) (
   input  wire logic                     clock,
   input  wire mac_ctl_type              ctl,
   input  wire logic signed [ELEM_W-1:0] op_a,
   input  wire logic signed [ELEM_W-1:0] op_b,
   input  wire logic [SHIFT_W-1:0]       shift,
   output logic signed [ELEM_W-1:0]      result
);

   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [ACC_BITS-1:0] acc_ff;
   logic signed [ACC_BITS-1:0] acc_in;
   logic signed [ACC_BITS-1:0] half;
   logic signed [ACC_BITS-1:0] shifted;

   // half an output step, none for a zero shift
   always_comb begin
      if (shift == '0) begin
         half = '0;
      end else begin
         half = ACC_BITS'(1) << (shift - SHIFT_W'(1));
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (ctl.acc_en) begin
         acc_in = acc_ff + ACC_BITS'(prod_ff);
      end else if (ctl.round_en) begin
         acc_in = acc_ff + half;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(op_a * op_b);
      acc_ff  <= acc_in;
   end

   assign shifted = acc_ff >>> shift;
   assign result  = shifted[ELEM_W-1:0];

endmodule

`default_nettype wire

[rtl/smm_seq.sv]
// ----------------------------------------------------------------------------
// smm_seq
// Sequencer: load pointers, output position, operand address walk and MAC control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smm_seq
   import smm_pkg::*;
#(
   parameter int IDX_W  = $clog2(DEF_MAX_DIM),
   parameter int ADDR_W = $clog2(DEF_MAX_DIM * DEF_MAX_DIM)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic [CMD_W-1:0]   req_cmd,
   output logic                    req_stall,
   input  wire logic               size_wr,
   input  wire logic [MODE_W-1:0]  mode,
   input  wire logic [IDX_W-1:0]   dim_last,
   input  wire logic [ADDR_W-1:0]  dim_step,
   input  wire logic [ADDR_W-1:0]  idx_last,
   input  wire logic               rsp_busy,
   output store_wr_type            store_wr,
   output logic [ADDR_W-1:0]       wr_addr,
   output logic [ADDR_W-1:0]       rd_addr_a,
   output logic [ADDR_W-1:0]       rd_addr_b,
   output mac_ctl_type             mac_ctl,
   output logic                    out_load,
   output logic                    out_last
);

   seq_state_type state_ff, state_in;

   logic [ADDR_W-1:0] ld_a_ptr_ff, ld_a_ptr_in;
   logic [ADDR_W-1:0] ld_b_ptr_ff, ld_b_ptr_in;
   logic [IDX_W-1:0]  row_ff, row_in;
   logic [IDX_W-1:0]  col_ff, col_in;
   logic [ADDR_W-1:0] row_base_ff, row_base_in;
   logic [ADDR_W-1:0] col_base_ff, col_base_in;
   logic [IDX_W-1:0]  k_ff, k_in;
   logic [ADDR_W-1:0] addr_a_ff, addr_a_in;
   logic [ADDR_W-1:0] addr_b_ff, addr_b_in;
   logic              last_ff, last_in;
   logic              rd_vld_ff, rd_vld_in;
   logic              mul_vld_ff;

   logic              a_trans;
   logic              b_trans;
   logic              accept;
   logic [ADDR_W-1:0] step_a;
   logic [ADDR_W-1:0] step_b;

   assign a_trans = (mode == MODE_A_T);
   assign b_trans = (mode == MODE_B_T);
   assign step_a  = a_trans ? dim_step : ADDR_W'(1);
   assign step_b  = b_trans ? ADDR_W'(1) : dim_step;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign wr_addr   = (req_cmd == CMD_LOAD_B) ? ld_b_ptr_ff : ld_a_ptr_ff;
   assign rd_addr_a = addr_a_ff;
   assign rd_addr_b = addr_b_ff;
   assign out_last  = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         ld_a_ptr_ff <= '0;
         ld_b_ptr_ff <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         row_base_ff <= '0;
         col_base_ff <= '0;
         rd_vld_ff   <= 1'b0;
         mul_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ld_a_ptr_ff <= ld_a_ptr_in;
         ld_b_ptr_ff <= ld_b_ptr_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         row_base_ff <= row_base_in;
         col_base_ff <= col_base_in;
         rd_vld_ff   <= rd_vld_in;
         mul_vld_ff  <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      addr_a_ff <= addr_a_in;
      addr_b_ff <= addr_b_in;
      last_ff   <= last_in;
   end

   always_comb begin
      state_in    = state_ff;
      ld_a_ptr_in = ld_a_ptr_ff;
      ld_b_ptr_in = ld_b_ptr_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      row_base_in = row_base_ff;
      col_base_in = col_base_ff;
      k_in        = k_ff;
      addr_a_in   = addr_a_ff;
      addr_b_in   = addr_b_ff;
      last_in     = last_ff;
      rd_vld_in   = 1'b0;
      store_wr    = '0;
      mac_ctl     = '0;
      mac_ctl.acc_en = mul_vld_ff;
      out_load    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  CMD_LOAD_A: begin
                     store_wr.we_a = 1'b1;
                     ld_a_ptr_in = (ld_a_ptr_ff == idx_last) ? '0 : ld_a_ptr_ff + ADDR_W'(1);
                  end
                  CMD_LOAD_B: begin
                     store_wr.we_b = 1'b1;
                     ld_b_ptr_in = (ld_b_ptr_ff == idx_last) ? '0 : ld_b_ptr_ff + ADDR_W'(1);
                  end
                  CMD_EMIT: begin
                     mac_ctl.clear = 1'b1;
                     k_in      = '0;
                     addr_a_in = a_trans ? ADDR_W'(row_ff) : row_base_ff;
                     addr_b_in = b_trans ? col_base_ff : ADDR_W'(col_ff);
                     last_in   = (row_ff == dim_last) && (col_ff == dim_last);
                     // step the output position in row-major order
                     if (col_ff == dim_last) begin
                        col_in      = '0;
                        col_base_in = '0;
                        if (row_ff == dim_last) begin
                           row_in      = '0;
                           row_base_in = '0;
                        end else begin
                           row_in      = row_ff + IDX_W'(1);
                           row_base_in = row_base_ff + dim_step;
                        end
                     end else begin
                        col_in      = col_ff + IDX_W'(1);
                        col_base_in = col_base_ff + dim_step;
                     end
                     state_in = ST_RUN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RUN: begin
            rd_vld_in = 1'b1;
            addr_a_in = addr_a_ff + step_a;
            addr_b_in = addr_b_ff + step_b;
            k_in      = k_ff + IDX_W'(1);
            if (k_ff == dim_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !mul_vld_ff) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            mac_ctl.round_en = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_busy) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a new size restarts both load pointers and the output position
      if (size_wr) begin
         ld_a_ptr_in = '0;
         ld_b_ptr_in = '0;
         row_in      = '0;
         col_in      = '0;
         row_base_in = '0;
         col_base_in = '0;
      end
   end

endmodule

`default_nettype wire

[rtl/square_matmul_round_shift.sv]
// ----------------------------------------------------------------------------
// square_matmul_round_shift
// Square matrix multiply with rounding right shift, one shared MAC unit.
// ----------------------------------------------------------------------------
// A user loads matrix A and matrix B one element per item in row-major order
// (cmd load A / load B) and then asks for product elements one per emit item,
// again in row-major order; the last element of the product is flagged. A
// load item is written into its store and the block is ready again in the
// next cycle. An emit item holds the input side while it walks matrix_size
// dot-product terms (size zero counts as one, sizes above MAX_DIM as
// MAX_DIM), one per cycle, on the single multiply-accumulate unit, fed by
// one read port on each element store; then while the read, multiply and
// accumulate registers empty, during the rounding add and while the result
// moves into the output register. If that register is still full and
// stalled, the block waits there. Each dot product accumulates in ACC_BITS
// two's complement with wrap, adds half an output step, shifts right
// arithmetically by round_shift and keeps the low 16 bits. Configuration
// writes are always taken (csr_ready is tied high) and belong to idle time;
// writing matrix_size restarts both load pointers and the output position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module square_matmul_round_shift
   import smm_pkg::*;
#(
   parameter int MAX_DIM  = DEF_MAX_DIM,
   parameter int ACC_BITS = DEF_ACC_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // input items
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [CMD_W-1:0]         req_cmd,
   input  wire logic signed [ELEM_W-1:0] req_element,
   // result items
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [ELEM_W-1:0]      rsp_product_element,
   output logic                          rsp_last_element,
   // configuration writes
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_data
);

   localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int AREA_W  = 2 * (SIZE_W + 1);
   localparam int RESET_N = (RESET_SIZE > MAX_DIM) ? MAX_DIM : RESET_SIZE;

   // ---- configuration ----
   // Only the effective size is kept, as last index, row step and last
   // element index; those are what the pointers and address walk need.
   logic [IDX_W-1:0]   dim_last_ff, dim_last_in;
   logic [ADDR_W-1:0]  dim_step_ff, dim_step_in;
   logic [ADDR_W-1:0]  idx_last_ff, idx_last_in;
   logic [SHIFT_W-1:0] shift_ff;
   logic [MODE_W-1:0]  mode_ff;

   logic [SIZE_W:0]    size_raw;
   logic [SIZE_W:0]    size_eff;
   logic [AREA_W-1:0]  area;
   logic               size_wr;

   assign csr_ready = 1'b1;
   assign size_wr   = csr_valid && (csr_index == CSR_MATRIX_SIZE);
   assign size_raw  = {1'b0, csr_data[SIZE_W-1:0]};

   // size zero acts as one, oversize clamps to the store dimension
   always_comb begin
      if (size_raw == '0) begin
         size_eff = (SIZE_W + 1)'(1);
      end else if (size_raw > (SIZE_W + 1)'(MAX_DIM)) begin
         size_eff = (SIZE_W + 1)'(MAX_DIM);
      end else begin
         size_eff = size_raw;
      end
      area        = AREA_W'(size_eff) * AREA_W'(size_eff);
      dim_last_in = IDX_W'(size_eff - (SIZE_W + 1)'(1));
      dim_step_in = ADDR_W'(size_eff);
      idx_last_in = ADDR_W'(area - AREA_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_last_ff <= IDX_W'(RESET_N - 1);
         dim_step_ff <= ADDR_W'(RESET_N);
         idx_last_ff <= ADDR_W'(RESET_N * RESET_N - 1);
         shift_ff    <= RESET_SHIFT;
         mode_ff     <= MODE_PLAIN;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MATRIX_SIZE: begin
               dim_last_ff <= dim_last_in;
               dim_step_ff <= dim_step_in;
               idx_last_ff <= idx_last_in;
            end
            CSR_ROUND_SHIFT: begin
               shift_ff <= csr_data[SHIFT_W-1:0];
            end
            CSR_TRANSPOSE: begin
               mode_ff <= csr_data[MODE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---- sequencer, stores, MAC ----
   store_wr_type             store_wr;
   mac_ctl_type              mac_ctl;
   logic [ADDR_W-1:0]        wr_addr;
   logic [ADDR_W-1:0]        rd_addr_a;
   logic [ADDR_W-1:0]        rd_addr_b;
   logic signed [ELEM_W-1:0] rd_data_a;
   logic signed [ELEM_W-1:0] rd_data_b;
   logic signed [ELEM_W-1:0] mac_result;
   logic                     out_load;
   logic                     out_last;
   logic                     rsp_busy;

   smm_seq #(
      .IDX_W  (IDX_W),
      .ADDR_W (ADDR_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .size_wr   (size_wr),
      .mode      (mode_ff),
      .dim_last  (dim_last_ff),
      .dim_step  (dim_step_ff),
      .idx_last  (idx_last_ff),
      .rsp_busy  (rsp_busy),
      .store_wr  (store_wr),
      .wr_addr   (wr_addr),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .mac_ctl   (mac_ctl),
      .out_load  (out_load),
      .out_last  (out_last)
   );

   smm_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock     (clock),
      .wr        (store_wr),
      .wr_addr   (wr_addr),
      .wr_data   (req_element),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   smm_mac #(
      .ACC_BITS (ACC_BITS)
   ) u_mac (
      .clock  (clock),
      .ctl    (mac_ctl),
      .op_a   (rd_data_a),
      .op_b   (rd_data_b),
      .shift  (shift_ff),
      .result (mac_result)
   );

   // ---- output register ----
   // Holds a finished item so the input side can take loads meanwhile.
   logic                     rsp_valid_ff;
   logic signed [ELEM_W-1:0] rsp_elem_ff;
   logic                     rsp_last_ff;

   assign rsp_busy = rsp_valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_elem_ff <= mac_result;
         rsp_last_ff <= out_last;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_product_element = rsp_elem_ff;
   assign rsp_last_element    = rsp_last_ff;

endmodule

`default_nettype wire

[rtl/smm_checker.sv]
// ----------------------------------------------------------------------------
// smm_checker
// Port-level checks of the matrix multiply block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module smm_checker
   import smm_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire logic [CMD_W-1:0]         req_cmd,
   input wire logic signed [ELEM_W-1:0] req_element,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic signed [ELEM_W-1:0] rsp_product_element,
   input wire logic                     rsp_last_element,
   input wire logic                     csr_valid,
   input wire logic                     csr_ready,
   input wire logic [CSR_INDEX_W-1:0]   csr_index,
   input wire logic [CSR_DATA_W-1:0]    csr_data
);

   logic req_take;
   logic cfg_take;

   assign req_take = req_valid && !req_stall;
   assign cfg_take = csr_valid && csr_ready && (csr_index == CSR_MATRIX_SIZE)
                     && (csr_data != '0) && (req_element != '0);

   // a stalled item stays and holds its payload
   `SMM_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)
   `SMM_ASSERT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_product_element) && $stable(rsp_last_element))

   // an emit occupies the MAC, so the input side stalls right after it
   `SMM_ASSERT(a_emit_busy, clock, reset, req_take && (req_cmd == CMD_EMIT) |=> req_stall)

   // loads never tie up the block
   `SMM_ASSERT(a_load_free, clock, reset, req_take && (req_cmd == CMD_LOAD_A || req_cmd == CMD_LOAD_B) && !cfg_take |=> !req_stall)

   // a result appears only at the end of an emit's busy period
   `SMM_ASSERT(a_rsp_from_emit, clock, reset, $rose(rsp_valid) |-> $past(req_stall))

endmodule

bind square_matmul_round_shift smm_checker u_smm_checker (.*);

`default_nettype wire
